/* sv/dithered_background_overlay_compositor_unit_defines.svh */
// Assertion macros shared by the compositor checker.
`ifndef DITHERED_BACKGROUND_OVERLAY_COMPOSITOR_UNIT_DEFINES_SVH
`define DITHERED_BACKGROUND_OVERLAY_COMPOSITOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBOC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dboc_pkg.sv */
// Shared types, constants and the Bayer table of the dithered compositor.
`timescale 1ns / 1ps
`default_nettype none

package dboc_pkg;

    localparam int SCREEN_WIDTH = 240;

    localparam int COL_W   = 8;   // screen column 0..255
    localparam int SHIFT_W = 9;   // signed overlay shift
    localparam int SRC_W   = 11;  // signed source column, -255..511
    localparam int BG_W    = 16;
    localparam int IDX_W   = 8;
    localparam int DATA_W  = 16;
    localparam int REG_W   = 2;

    typedef enum logic [REG_W-1:0] {
        REG_OVERLAY_SHIFT    = 2'd0,
        REG_BACKGROUND_SHIFT = 2'd1,
        REG_DARK_INDEX       = 2'd2,
        REG_LIGHT_INDEX      = 2'd3
    } dboc_reg_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] overlay_shift;
        logic [BG_W-1:0]    background_shift;
        logic [IDX_W-1:0]   dark_index;
        logic [IDX_W-1:0]   light_index;
    } dboc_cfg_t;

    localparam logic [IDX_W-1:0] DARK_RESET  = 8'd5;
    localparam logic [IDX_W-1:0] LIGHT_RESET = 8'd6;

    localparam logic [3:0] BAYER [4][4] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6},
        '{4'd3,  4'd11, 4'd1,  4'd9},
        '{4'd15, 4'd7,  4'd13, 4'd5}
    };

endpackage

`default_nettype wire

/* sv/dboc_cfg_regs.sv */
// Configuration register file of the dithered compositor.
`timescale 1ns / 1ps
`default_nettype none

module dboc_cfg_regs
    import dboc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [REG_W-1:0]  wr_index,
    input  wire logic [DATA_W-1:0] wr_data,
    output dboc_cfg_t              cfg
);

    dboc_cfg_t cfg_reg;
    dboc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (dboc_reg_t'(wr_index))
                REG_OVERLAY_SHIFT:    cfg_next.overlay_shift    = wr_data[SHIFT_W-1:0];
                REG_BACKGROUND_SHIFT: cfg_next.background_shift = wr_data[BG_W-1:0];
                REG_DARK_INDEX:       cfg_next.dark_index       = wr_data[IDX_W-1:0];
                REG_LIGHT_INDEX:      cfg_next.light_index      = wr_data[IDX_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overlay_shift    <= '0;
            cfg_reg.background_shift <= '0;
            cfg_reg.dark_index       <= DARK_RESET;
            cfg_reg.light_index      <= LIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/dboc_pixel.sv */
// One pixel: Bayer-dithered background index with overlay composited on top.
`timescale 1ns / 1ps
`default_nettype none

module dboc_pixel
    import dboc_pkg::*;
(
    input  wire logic [COL_W-1:0] col,
    input  wire logic [1:0]       row4,
    input  wire logic [IDX_W-1:0] ovl,
    input  wire dboc_cfg_t        cfg,
    output logic      [IDX_W-1:0] idx
);

    logic [6:0]           mix;
    logic [3:0]           intensity;
    logic [3:0]           thr;
    logic [IDX_W-1:0]     bg_idx;
    logic signed [SRC_W-1:0] src;
    logic                 on_screen;

    // Only the low seven bits of the sum reach intensity bits [6:3].
    assign mix       = col[6:0] + cfg.background_shift[6:0];
    assign intensity = mix[6:3];
    assign thr       = BAYER[row4][col[1:0]];
    assign bg_idx    = (intensity > thr) ? cfg.light_index : cfg.dark_index;

    assign src = $signed({{(SRC_W-COL_W){1'b0}}, col})
               - $signed({{(SRC_W-SHIFT_W){cfg.overlay_shift[SHIFT_W-1]}}, cfg.overlay_shift});
    assign on_screen = !src[SRC_W-1] && ($unsigned(src) < SRC_W'(SCREEN_WIDTH));

    // Zero overlay is the transparent key.
    assign idx = (on_screen && (ovl != '0)) ? ovl : bg_idx;

endmodule

`default_nettype wire

/* sv/dithered_background_overlay_compositor_unit.sv */
// Top level of the dithered background / overlay compositor.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------------
//  input     | start, busy        | pair_column, line_number, overlay_left/right
//  result    | done (strobe)      | pixel_word
//  config    | wr_en              | wr_index, wr_data
//
// One pixel pair per clock: busy stays low, a transfer can happen every cycle.
// Data passes the input register, then both pixel units feed the result register.
// The result shows on pixel_word for the single cycle in which done is high.
// The receiver has no stall; results are never held back.
// Reset clears the valid flags and loads the register defaults (dark 5, light 6).
`timescale 1ns / 1ps
`default_nettype none

module dithered_background_overlay_compositor_unit
    import dboc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write port
    input  wire logic              wr_en,
    input  wire logic [REG_W-1:0]  wr_index,
    input  wire logic [DATA_W-1:0] wr_data,
    // input command
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [6:0]        pair_column,
    input  wire logic [7:0]        line_number,
    input  wire logic [IDX_W-1:0]  overlay_left,
    input  wire logic [IDX_W-1:0]  overlay_right,
    // result
    output logic                   done,
    output logic [DATA_W-1:0]      pixel_word
);

    dboc_cfg_t cfg;

    logic             in_valid_reg;
    logic [6:0]       pair_reg;
    logic [1:0]       row4_reg;
    logic [IDX_W-1:0] ovl_left_reg;
    logic [IDX_W-1:0] ovl_right_reg;

    logic             done_reg;
    logic [DATA_W-1:0] pixel_word_reg;
    logic [DATA_W-1:0] pixel_word_next;

    logic [IDX_W-1:0] idx_left;
    logic [IDX_W-1:0] idx_right;

    // The pipeline never backs up, so every start is a transfer.
    assign busy = 1'b0;

    dboc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Stage 1: capture the pair; only the low two line bits pick the Bayer row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            pair_reg      <= pair_column;
            row4_reg      <= line_number[1:0];
            ovl_left_reg  <= overlay_left;
            ovl_right_reg <= overlay_right;
        end
    end

    // Left pixel sits on the even column, right pixel on the odd one.
    dboc_pixel u_pix_left (
        .col  ({pair_reg, 1'b0}),
        .row4 (row4_reg),
        .ovl  (ovl_left_reg),
        .cfg  (cfg),
        .idx  (idx_left)
    );

    dboc_pixel u_pix_right (
        .col  ({pair_reg, 1'b1}),
        .row4 (row4_reg),
        .ovl  (ovl_right_reg),
        .cfg  (cfg),
        .idx  (idx_right)
    );

    // Pack: low byte left index, high byte right index.
    assign pixel_word_next = {idx_right, idx_left};

    // Stage 2: result register, strobed for exactly one cycle per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            pixel_word_reg <= pixel_word_next;
        end
    end

    assign done       = done_reg;
    assign pixel_word = pixel_word_reg;

endmodule

`default_nettype wire

/* sv/dboc_checker.sv */
// Port-level checker for the compositor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "dithered_background_overlay_compositor_unit_defines.svh"

module dboc_checker
    import dboc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              wr_en,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [6:0]        pair_column,
    input wire logic [7:0]        line_number,
    input wire logic [IDX_W-1:0]  overlay_left,
    input wire logic [IDX_W-1:0]  overlay_right,
    input wire logic              done,
    input wire logic [DATA_W-1:0] pixel_word
);

    // Every transfer yields its strobe once it has passed the input and result registers.
    `DBOC_ASSERT_SAME(a_result_follows, clk, rst_n, start && !busy, ##2 done, "missing result strobe")

    // No strobe without a transfer that went before it through both registers.
    `DBOC_ASSERT_SAME(a_no_phantom, clk, rst_n, done, $past(start && !busy, 2), "result without transfer")

    // Identical back-to-back pairs under unchanged registers give identical words.
    `DBOC_ASSERT_NEXT(a_repeat_same, clk, rst_n, start && !busy && $past(start && !busy) && !wr_en && $stable(pair_column) && $stable(line_number) && $stable(overlay_left) && $stable(overlay_right), ##1 (done && $stable(pixel_word)), "repeated pair gave different word")

endmodule

bind dithered_background_overlay_compositor_unit dboc_checker u_dboc_checker (.*);

`default_nettype wire

/* verif/tb_dithered_background_overlay_compositor_unit.sv */
// Self-checking testbench for the dithered background / overlay compositor.
`timescale 1ns / 1ps

import dboc_pkg::*;

// Tracks the register copy and the display words still owed by the block.
class pixel_word_scoreboard;
    logic signed [8:0] ovl_shift;
    logic [15:0]       bg_shift;
    logic [7:0]        dark_idx;
    logic [7:0]        light_idx;
    bit [3:0]          bayer [4][4];
    logic [15:0]       owed_words [$];
    int unsigned       pairs_seen;
    int unsigned       words_checked;
    int unsigned       mismatches;

    function new();
        bayer = '{'{0, 8, 2, 10}, '{12, 4, 14, 6}, '{3, 11, 1, 9}, '{15, 7, 13, 5}};
        ovl_shift = 9'sd0;
        bg_shift = 16'd0;
        dark_idx = 8'd5;
        light_idx = 8'd6;
        pairs_seen = 0;
        words_checked = 0;
        mismatches = 0;
    endfunction

    // Keep only the low bits of each register, as the hardware does.
    function void write_reg(dboc_reg_t idx, logic [15:0] data);
        case (idx)
            REG_OVERLAY_SHIFT:    ovl_shift = data[8:0];
            REG_BACKGROUND_SHIFT: bg_shift = data;
            REG_DARK_INDEX:       dark_idx = data[7:0];
            REG_LIGHT_INDEX:      light_idx = data[7:0];
            default: ;
        endcase
    endfunction

    function logic [7:0] pick_index(logic [7:0] col, logic [1:0] row, logic [7:0] ovl);
        logic [16:0] sum;
        logic [3:0]  level;
        logic [7:0]  idx;
        int          src;
        sum = {9'd0, col} + {1'b0, bg_shift};
        level = sum[6:3];
        idx = (level > bayer[row][col[1:0]]) ? light_idx : dark_idx;
        src = int'(col) - int'(ovl_shift);
        if (src >= 0 && src < SCREEN_WIDTH && ovl != 8'd0)
            idx = ovl;
        return idx;
    endfunction

    function void note_pair(logic [6:0] pc, logic [7:0] ln, logic [7:0] ol, logic [7:0] orr);
        logic [7:0] col;
        col = {pc, 1'b0};
        owed_words.push_back({pick_index(col | 8'd1, ln[1:0], orr),
                              pick_index(col, ln[1:0], ol)});
        pairs_seen++;
    endfunction

    task report(string msg);
        $display("  mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task check_word(logic [15:0] got);
        logic [15:0] want;
        if (owed_words.size() == 0) begin
            report($sformatf("pixel_word %h with nothing outstanding", got));
            return;
        end
        want = owed_words.pop_front();
        words_checked++;
        if (got !== want)
            report($sformatf("pixel_word got %h want %h", got, want));
    endtask

    function int unsigned outstanding();
        return owed_words.size();
    endfunction
endclass

module tb_dithered_background_overlay_compositor_unit;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 8;
    localparam int PAIRS_PER_PH = 244;
    localparam int DRAIN_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              wr_en;
    dboc_reg_t         wr_index;
    logic [15:0]       wr_data;
    logic              start;
    logic              busy;
    logic [6:0]        pair_column;
    logic [7:0]        line_number;
    logic [7:0]        overlay_left;
    logic [7:0]        overlay_right;
    logic              done;
    logic [15:0]       pixel_word;

    pixel_word_scoreboard sb;
    int unsigned          reg_writes;

    dithered_background_overlay_compositor_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .start        (start),
        .busy         (busy),
        .pair_column  (pair_column),
        .line_number  (line_number),
        .overlay_left (overlay_left),
        .overlay_right(overlay_right),
        .done         (done),
        .pixel_word   (pixel_word)
    );

    // 12 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: the slowest legal run is far below this many cycles.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("  timeout after %0d cycles, %0d words outstanding", CYCLE_LIMIT,
                 sb.outstanding());
        $display("[dithered_background_overlay_compositor_unit] ERROR");
        $finish;
    end

    // Monitor: every decision is made on values that were stable before the edge.
    // Note the accepted pair before checking, so the order holds at any latency.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (wr_en)
                sb.write_reg(wr_index, wr_data);
            if (start && !busy)
                sb.note_pair(pair_column, line_number, overlay_left, overlay_right);
            if (done)
                sb.check_word(pixel_word);
        end
    end

    // Present one pixel pair from a falling edge and hold it until the transfer.
    // Return at the falling edge after the transfer with start still high.
    task automatic send_pair(input logic [6:0] pc, input logic [7:0] ln,
                             input logic [7:0] ol, input logic [7:0] orr);
        start = 1'b1;
        pair_column = pc;
        line_number = ln;
        overlay_left = ol;
        overlay_right = orr;
        forever begin
            @(posedge clk);
            if (!busy)
                break;
        end
        @(negedge clk);
    endtask

    // Mostly on-screen pairs; the rest reach the columns past the line.
    // About a third of the overlay pixels are transparent.
    task automatic send_random_pair();
        logic [6:0] pc;
        logic [7:0] ol;
        logic [7:0] orr;
        pc = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 119));
        ol = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        orr = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        send_pair(pc, 8'($urandom), ol, orr);
    endtask

    // Drop start and let the given number of cycles pass.
    task automatic hold_idle(input int unsigned cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // One-cycle register write, launched at a falling edge.
    task automatic write_reg(input dboc_reg_t idx, input logic [15:0] data);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = data;
        @(negedge clk);
        wr_en = 1'b0;
        reg_writes++;
    endtask

    // Wait until every owed word has come back; the block has one word per pair,
    // so an empty store means the pipeline is empty too.
    task automatic drain();
        start = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic load_phase_regs(input int ph);
        case (ph)
            // Leftmost shift, widest background offset, full index range.
            1: begin
                write_reg(REG_OVERLAY_SHIFT, 16'h0100);
                write_reg(REG_BACKGROUND_SHIFT, 16'hFFFF);
                write_reg(REG_DARK_INDEX, 16'h0000);
                write_reg(REG_LIGHT_INDEX, 16'h00FF);
            end
            // Rightmost shift, zero offset, swapped index extremes.
            2: begin
                write_reg(REG_OVERLAY_SHIFT, 16'h00FF);
                write_reg(REG_BACKGROUND_SHIFT, 16'h0000);
                write_reg(REG_DARK_INDEX, 16'h00FF);
                write_reg(REG_LIGHT_INDEX, 16'h0000);
            end
            // Junk in the upper bits must be dropped; shift lands on -1.
            3: begin
                write_reg(REG_OVERLAY_SHIFT, 16'hFFFF);
                write_reg(REG_BACKGROUND_SHIFT, 16'h8000);
                write_reg(REG_DARK_INDEX, 16'hAB12);
                write_reg(REG_LIGHT_INDEX, 16'hFF34);
            end
            // Random words; the upper bits are random too.
            default: begin
                write_reg(REG_OVERLAY_SHIFT, 16'($urandom));
                write_reg(REG_BACKGROUND_SHIFT, 16'($urandom));
                write_reg(REG_DARK_INDEX, 16'($urandom));
                write_reg(REG_LIGHT_INDEX, 16'($urandom));
            end
        endcase
    endtask

    initial
    begin
        int unsigned left;
        int unsigned burst;
        int unsigned gap;

        sb = new();
        reg_writes = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_OVERLAY_SHIFT;
        wr_data = 16'd0;
        start = 1'b0;
        pair_column = 7'd0;
        line_number = 8'd0;
        overlay_left = 8'd0;
        overlay_right = 8'd0;

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed pairs under the reset defaults (shift 0, dark 5, light 6).
        send_pair(7'd0,   8'd0,   8'd0,   8'd0);     // all background, first pair
        send_pair(7'd0,   8'd0,   8'd255, 8'd1);     // overlay extremes on top
        send_pair(7'd1,   8'd1,   8'd0,   8'd0);
        send_pair(7'd2,   8'd2,   8'd0,   8'd0);
        send_pair(7'd3,   8'd3,   8'd0,   8'd0);
        send_pair(7'd4,   8'd0,   8'd0,   8'd0);     // intensity steps up
        send_pair(7'd31,  8'd3,   8'd0,   8'd0);
        send_pair(7'd60,  8'd1,   8'd0,   8'hAA);    // only the right pixel overlaid
        send_pair(7'd60,  8'd2,   8'h55,  8'd0);     // only the left pixel overlaid
        send_pair(7'd119, 8'd159, 8'd0,   8'd0);     // last pair on the line
        send_pair(7'd119, 8'd3,   8'd255, 8'd255);   // overlay on the last column
        hold_idle(3);
        send_pair(7'd120, 8'd1,   8'd7,   8'd9);     // past the line: overlay dropped
        send_pair(7'd127, 8'd255, 8'd255, 8'd255);   // widest column and line
        send_pair(7'd127, 8'd2,   8'h80,  8'h7F);
        send_pair(7'd64,  8'd160, 8'd0,   8'd0);     // line past the screen
        send_pair(7'd85,  8'd254, 8'h01,  8'hFE);
        hold_idle(1);
        send_pair(7'd42,  8'd128, 8'd0,   8'd0);
        send_pair(7'd100, 8'd99,  8'd0,   8'd0);
        hold_idle(2);

        // Random phases: after phase 0, write the registers while idle, then stream pairs in
        // bursts. Phase 3 streams back to back with no gaps at all.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph != 0)
                load_phase_regs(ph);
            left = PAIRS_PER_PH;
            while (left != 0) begin
                burst = $urandom_range(1, 24);
                if (burst > left)
                    burst = left;
                repeat (burst) send_random_pair();
                left -= burst;
                if (ph == 3 || $urandom_range(0, 3) == 0)
                    gap = 0;
                else
                    gap = $urandom_range(1, 6);
                if (gap != 0)
                    hold_idle(gap);
            end
        end

        // Wait for the last words, then keep watching for strays before the final check.
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d words never arrived", sb.outstanding()));

        $display("  %0d pixel pairs sent, %0d words checked, %0d register writes",
                 sb.pairs_seen, sb.words_checked, reg_writes);
        $display("  %0d register settings incl. shift and index extremes, %0d mismatches",
                 PHASES, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[dithered_background_overlay_compositor_unit] OK");
        else
            $display("[dithered_background_overlay_compositor_unit] ERROR");
        $finish;
    end

endmodule
